FILE: src/cst_pkg.sv
// shared types, constants and crc helpers for the character stream tokenizer
package cst_pkg;

  localparam int COLUMN_BITS = 16;
  localparam int TOKCOL_BITS = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [31:0] KW_SUB   = 32'h580282dc;
  localparam logic [31:0] KW_END   = 32'h00fc33b1;
  localparam logic [31:0] CRC_INIT = 32'hffffffff;

  localparam logic [7:0] CH_NEWLINE = 8'h0a;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DOT     = 8'h2e;

  typedef enum logic [2:0] {
    CC_NEWLINE,
    CC_SPACE,
    CC_DOT,
    CC_DIGIT,
    CC_ALPHA,
    CC_OTHER
  } char_class_t;

  typedef enum logic [2:0] {
    LX_START = 3'd0,
    LX_DOT   = 3'd1,
    LX_INT   = 3'd2,
    LX_FRAC  = 3'd3,
    LX_NAME  = 3'd4,
    LX_DONE  = 3'd5
  } lex_state_t;

  typedef enum logic [2:0] {
    TC_SINGLE = 3'd0,
    TC_NUMBER = 3'd1,
    TC_NAME   = 3'd2,
    TC_KW_SUB = 3'd3,
    TC_KW_END = 3'd4
  } token_class_t;

  typedef struct packed {
    logic [7:0]  character;
    char_class_t cclass;
  } queue_entry_t;

  // nibble table of the reflected crc-32 polynomial
  function automatic logic [31:0] nib_lookup(input logic [3:0] idx);
    logic [31:0] v;
    case (idx)
      4'h0: v = 32'h00000000;
      4'h1: v = 32'h1db71064;
      4'h2: v = 32'h3b6e20c8;
      4'h3: v = 32'h26d930ac;
      4'h4: v = 32'h76dc4190;
      4'h5: v = 32'h6b6b51f4;
      4'h6: v = 32'h4db26158;
      4'h7: v = 32'h5005713c;
      4'h8: v = 32'hedb88320;
      4'h9: v = 32'hf00f9344;
      4'ha: v = 32'hd6d6a3e8;
      4'hb: v = 32'hcb61b38c;
      4'hc: v = 32'h9b64c2b0;
      4'hd: v = 32'h86d3d2d4;
      4'he: v = 32'ha00ae278;
      default: v = 32'hbdbdf21c;
    endcase
    return v;
  endfunction

  // one character into the crc, low nibble first
  function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] ch);
    logic [31:0] t;
    t = nib_lookup(crc[3:0] ^ ch[3:0]) ^ (crc >> 4);
    t = nib_lookup(t[3:0] ^ ch[7:4]) ^ (t >> 4);
    return t;
  endfunction

endpackage

FILE: src/cst_front.sv
// front end: takes characters, classifies them and pushes them into the queue
module cst_front (
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           character,
  input  logic                 q_full,
  output logic                 q_push,
  output cst_pkg::queue_entry_t q_wdata
);
  import cst_pkg::*;

  char_class_t cc;

  always_comb begin
    if (character == CH_NEWLINE) begin
      cc = CC_NEWLINE;
    end else if (character <= CH_SPACE) begin
      cc = CC_SPACE;
    end else if (character == CH_DOT) begin
      cc = CC_DOT;
    end else if (character >= 8'h30 && character <= 8'h39) begin
      cc = CC_DIGIT;
    end else if ((character >= 8'h61 && character <= 8'h7a) ||
                 (character >= 8'h41 && character <= 8'h5a) ||
                 (character == 8'h5f)) begin
      cc = CC_ALPHA;
    end else begin
      cc = CC_OTHER;
    end
  end

  assign in_stall          = q_full;
  assign q_push            = in_valid && !q_full;
  assign q_wdata.character = character;
  assign q_wdata.cclass    = cc;

endmodule

FILE: src/cst_queue.sv
// short queue of classified characters between front and back
module cst_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  cst_pkg::queue_entry_t wdata,
  input  logic                  pop,
  output cst_pkg::queue_entry_t rdata,
  output logic                  full,
  output logic                  empty
);
  import cst_pkg::*;

  queue_entry_t             mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]     wptr;
  logic [QPTR_BITS-1:0]     rptr;
  logic [QCNT_BITS-1:0]     count;

  assign full  = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

FILE: src/cst_back.sv
// back end: lexer state machine, column tracking, name crc and result register
module cst_back (
  input  logic                  clk,
  input  logic                  rst,
  input  cst_pkg::queue_entry_t q_rdata,
  input  logic                  q_empty,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  consumed,
  output logic                  token_done,
  output logic [2:0]            token_class,
  output logic [7:0]            token_char,
  output logic [15:0]           token_column,
  output logic [31:0]           name_hash
);
  import cst_pkg::*;

  lex_state_t             state;
  lex_state_t             state_next;
  lex_state_t             eff_state;
  logic [COLUMN_BITS-1:0] column;
  logic [COLUMN_BITS-1:0] column_next;
  logic [COLUMN_BITS-1:0] start_column;
  logic [COLUMN_BITS-1:0] start_column_next;
  logic [31:0]            running_crc;
  logic [31:0]            running_crc_next;
  logic [31:0]            crc_fin;
  logic [7:0]             ch;
  char_class_t            cc;
  logic                   used;
  logic                   done;
  token_class_t           cls;
  logic [7:0]             tch;
  logic [31:0]            hash;
  logic [TOKCOL_BITS-1:0] start_col16;

  assign ch        = q_rdata.character;
  assign cc        = q_rdata.cclass;
  assign q_pop     = !q_empty && (!out_valid || !out_stall);
  assign eff_state = (state == LX_DONE) ? LX_START : state;
  assign crc_fin   = ~running_crc;

  // next state
  always_comb begin
    state_next = eff_state;
    unique case (eff_state)
      LX_START: begin
        unique case (cc)
          CC_NEWLINE, CC_OTHER: state_next = LX_DONE;
          CC_SPACE:             state_next = LX_START;
          CC_DOT:               state_next = LX_DOT;
          CC_DIGIT:             state_next = LX_INT;
          CC_ALPHA:             state_next = LX_NAME;
          default:              state_next = LX_DONE;
        endcase
      end
      LX_DOT: begin
        state_next = (cc == CC_DIGIT) ? LX_FRAC : LX_DONE;
      end
      LX_INT: begin
        if (cc == CC_DIGIT) begin
          state_next = LX_INT;
        end else if (cc == CC_DOT) begin
          state_next = LX_FRAC;
        end else begin
          state_next = LX_DONE;
        end
      end
      LX_FRAC: begin
        state_next = (cc == CC_DIGIT) ? LX_FRAC : LX_DONE;
      end
      LX_NAME: begin
        state_next = (cc == CC_ALPHA || cc == CC_DIGIT) ? LX_NAME : LX_DONE;
      end
      default: state_next = LX_START;
    endcase
  end

  // outputs and datapath updates
  always_comb begin
    used              = 1'b0;
    done              = 1'b0;
    cls               = TC_SINGLE;
    tch               = '0;
    hash              = '0;
    start_column_next = start_column;
    running_crc_next  = running_crc;
    unique case (eff_state)
      LX_START: begin
        used = 1'b1;
        if (cc != CC_SPACE) begin
          start_column_next = column;
        end
        if (cc == CC_NEWLINE || cc == CC_OTHER) begin
          done = 1'b1;
          tch  = ch;
        end
        if (cc == CC_ALPHA) begin
          running_crc_next = crc_step(CRC_INIT, ch);
        end
      end
      LX_DOT: begin
        if (cc == CC_DIGIT) begin
          used = 1'b1;
        end else begin
          done = 1'b1;
          tch  = CH_DOT;
        end
      end
      LX_INT: begin
        if (cc == CC_DIGIT || cc == CC_DOT) begin
          used = 1'b1;
        end else begin
          done = 1'b1;
          cls  = TC_NUMBER;
        end
      end
      LX_FRAC: begin
        if (cc == CC_DIGIT) begin
          used = 1'b1;
        end else begin
          done = 1'b1;
          cls  = TC_NUMBER;
        end
      end
      LX_NAME: begin
        if (cc == CC_ALPHA || cc == CC_DIGIT) begin
          used             = 1'b1;
          running_crc_next = crc_step(running_crc, ch);
        end else begin
          done             = 1'b1;
          running_crc_next = crc_fin;
          hash             = crc_fin;
          if (crc_fin == KW_SUB) begin
            cls = TC_KW_SUB;
          end else if (crc_fin == KW_END) begin
            cls = TC_KW_END;
          end else begin
            cls = TC_NAME;
          end
        end
      end
      default: begin
        used = 1'b0;
      end
    endcase
  end

  // column advance, saturating
  always_comb begin
    column_next = column;
    if (used) begin
      if (cc == CC_NEWLINE) begin
        column_next = COLUMN_BITS'(1);
      end else if (column != '1) begin
        column_next = column + 1'b1;
      end
    end
  end

  generate
    if (COLUMN_BITS >= TOKCOL_BITS) begin : g_col_trunc
      assign start_col16 = start_column_next[TOKCOL_BITS-1:0];
    end else begin : g_col_ext
      assign start_col16 = TOKCOL_BITS'(start_column_next);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= LX_START;
      column       <= COLUMN_BITS'(1);
      start_column <= COLUMN_BITS'(1);
      running_crc  <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (q_pop) begin
        state        <= state_next;
        column       <= column_next;
        start_column <= start_column_next;
        running_crc  <= running_crc_next;
        out_valid    <= 1'b1;
      end else if (!out_stall) begin
        out_valid    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      consumed     <= used;
      token_done   <= done;
      token_class  <= done ? cls : TC_SINGLE;
      token_char   <= done ? tch : 8'h00;
      token_column <= done ? start_col16 : '0;
      name_hash    <= done ? hash : 32'h0;
    end
  end

endmodule

FILE: src/char_stream_tokenizer_top.sv
// top level of the character stream tokenizer
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------------
//   input   | in        | in_valid / in_stall    | character
//   output  | out       | out_valid / out_stall  | consumed, token_done, token_class,
//           |           |                        | token_char, token_column, name_hash
//
// one character per cycle sustained while out_stall stays low; every accepted item gives
//   exactly one result item; an item is written into the queue, then the lexer step puts
//   its result into the result register; the lexer state, column and crc update once per item
// rst is synchronous and clears the queue, the lexer state, the column counters and crc
// a stalled output holds the result register; the queue keeps taking items until it is
//   full, and in_stall is raised only by a full queue
module char_stream_tokenizer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  character,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        consumed,
  output logic        token_done,
  output logic [2:0]  token_class,
  output logic [7:0]  token_char,
  output logic [15:0] token_column,
  output logic [31:0] name_hash
);
  import cst_pkg::*;

  // queue handshake between front and back
  queue_entry_t q_wdata;
  queue_entry_t q_rdata;
  logic         q_push;
  logic         q_pop;
  logic         q_full;
  logic         q_empty;

  // front: classify each character and push it
  cst_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .character (character),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  // short queue decoupling the two halves
  cst_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  // back: lexer step and result register
  cst_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_rdata      (q_rdata),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .consumed     (consumed),
    .token_done   (token_done),
    .token_class  (token_class),
    .token_char   (token_char),
    .token_column (token_column),
    .name_hash    (name_hash)
  );

endmodule

FILE: bench/char_stream_tokenizer_top_test.sv
// self-checking testbench for the character stream tokenizer top level
module char_stream_tokenizer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cst_pkg::*;

  // reflected crc-32 polynomial, used bit by bit in the predictor
  localparam logic [31:0] CRC_POLY = 32'hedb88320;
  // run limit in ns, set with a wide margin over the slowest correct run
  localparam int RUN_LIMIT_NS = 5_000_000;

  // one result item as the block should give it
  typedef struct packed {
    logic        consumed;
    logic        token_done;
    logic [2:0]  token_class;
    logic [7:0]  token_char;
    logic [15:0] token_column;
    logic [31:0] name_hash;
  } lex_result_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  character;
  logic        out_valid;
  logic        out_stall;
  logic        consumed;
  logic        token_done;
  logic [2:0]  token_class;
  logic [7:0]  token_char;
  logic [15:0] token_column;
  logic [31:0] name_hash;

  // predictor state, a private copy of what the lexer holds
  lex_state_t             lx;
  logic [COLUMN_BITS-1:0] cur_col;
  logic [COLUMN_BITS-1:0] tok_col;
  logic [31:0]            name_crc;

  // results still owed by the block, oldest first
  lex_result_t lex_results_due[$];

  int  mismatch_count = 0;
  int  items_sent     = 0;
  bit  tx_idle_en     = 1'b0;
  bit  rx_idle_en     = 1'b0;
  int  rx_hold_cycles = 0;

  string kw_words[6] = '{"sub", "end", "SUB", "End", "subs", "en"};
  string op_chars    = "+-*/()^=";

  char_stream_tokenizer_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .character    (character),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .consumed     (consumed),
    .token_done   (token_done),
    .token_class  (token_class),
    .token_char   (token_char),
    .token_column (token_column),
    .name_hash    (name_hash)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // one character into the running crc, one bit at a time, lsb first
  function automatic logic [31:0] crc_bitwise(input logic [31:0] crc, input logic [7:0] ch);
    logic [31:0] v;
    v = crc ^ {24'd0, ch};
    for (int b = 0; b < 8; b++) begin
      v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
    end
    return v;
  endfunction

  // advance the lexer by one character and return the result it owes
  function automatic lex_result_t lex_char(input logic [7:0] ch);
    lex_result_t r;
    logic        is_dig;
    logic        is_lead;
    logic [31:0] hash;
    r       = '0;
    is_dig  = (ch >= "0") && (ch <= "9");
    is_lead = ((ch >= "a") && (ch <= "z")) || ((ch >= "A") && (ch <= "Z")) || (ch == "_");
    hash    = '0;

    // a finished token hands over to start, and the same character is lexed there
    if (lx >= LX_DONE) lx = LX_START;

    case (lx)
      LX_START: begin
        r.consumed = 1'b1;
        if (ch == CH_NEWLINE) begin
          tok_col = cur_col;
          r.token_done = 1'b1;
          r.token_class = TC_SINGLE;
          r.token_char = ch;
          lx = LX_DONE;
        end else if (ch <= CH_SPACE) begin
          // whitespace, nothing happens
        end else if (ch == CH_DOT) begin
          tok_col = cur_col;
          lx = LX_DOT;
        end else if (is_dig) begin
          tok_col = cur_col;
          lx = LX_INT;
        end else if (is_lead) begin
          tok_col = cur_col;
          name_crc = crc_bitwise(CRC_INIT, ch);
          lx = LX_NAME;
        end else begin
          tok_col = cur_col;
          r.token_done = 1'b1;
          r.token_class = TC_SINGLE;
          r.token_char = ch;
          lx = LX_DONE;
        end
      end
      LX_DOT: begin
        if (is_dig) begin
          r.consumed = 1'b1;
          lx = LX_FRAC;
        end else begin
          r.token_done = 1'b1;
          r.token_class = TC_SINGLE;
          r.token_char = CH_DOT;
          lx = LX_DONE;
        end
      end
      LX_INT: begin
        if (is_dig) begin
          r.consumed = 1'b1;
        end else if (ch == CH_DOT) begin
          r.consumed = 1'b1;
          lx = LX_FRAC;
        end else begin
          r.token_done = 1'b1;
          r.token_class = TC_NUMBER;
          lx = LX_DONE;
        end
      end
      LX_FRAC: begin
        if (is_dig) begin
          r.consumed = 1'b1;
        end else begin
          r.token_done = 1'b1;
          r.token_class = TC_NUMBER;
          lx = LX_DONE;
        end
      end
      default: begin
        if (is_lead || is_dig) begin
          r.consumed = 1'b1;
          name_crc = crc_bitwise(name_crc, ch);
        end else begin
          name_crc = ~name_crc;
          hash = name_crc;
          if (hash == KW_SUB) r.token_class = TC_KW_SUB;
          else if (hash == KW_END) r.token_class = TC_KW_END;
          else r.token_class = TC_NAME;
          r.name_hash = hash;
          r.token_done = 1'b1;
          lx = LX_DONE;
        end
      end
    endcase

    if (r.token_done) r.token_column = tok_col[15:0];

    // column moves only on a consumed character and sticks at its maximum
    if (r.consumed) begin
      if (ch == CH_NEWLINE) cur_col = COLUMN_BITS'(1);
      else if (cur_col != {COLUMN_BITS{1'b1}}) cur_col = cur_col + 1'b1;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // offer one item, wait for it to be taken, then record what it should produce
  task automatic send_char(input logic [7:0] ch, output logic took);
    lex_result_t r;
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    character <= ch;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = lex_char(ch);
    lex_results_due.push_back(r);
    items_sent++;
    took = r.consumed;
  endtask

  // well-formed use: a character the lexer did not take is offered again
  task automatic send_until_taken(input logic [7:0] ch);
    logic took;
    do send_char(ch, took); while (!took);
  endtask

  task automatic send_text(input string s);
    for (int k = 0; k < s.len(); k++) send_until_taken(s[k]);
  endtask

  // sender goes quiet until the block has returned every result
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (lex_results_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_name_char(input bit lead);
    int k;
    k = $urandom_range(0, lead ? 52 : 62);
    if (k < 26) return 8'("a" + k);
    else if (k < 52) return 8'("A" + k - 26);
    else if (k == 52) return "_";
    else return 8'("0" + k - 53);
  endfunction

  // whitespace other than newline
  function automatic logic [7:0] rand_blank();
    logic [7:0] ch;
    ch = 8'($urandom_range(0, 32));
    return (ch == CH_NEWLINE) ? CH_SPACE : ch;
  endfunction

  // ---------------------------------------------------------------------------
  // receiver side: random stall bursts, plus one long hold on request
  // ---------------------------------------------------------------------------
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
        out_stall <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string fname, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", fname, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    lex_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (lex_results_due.size() == 0) begin
        $error("result item with no expectation pending");
        mismatch_count++;
      end else begin
        want = lex_results_due.pop_front();
        check_field("consumed", 32'(want.consumed), 32'(consumed));
        check_field("token_done", 32'(want.token_done), 32'(token_done));
        check_field("token_class", 32'(want.token_class), 32'(token_class));
        check_field("token_char", 32'(want.token_char), 32'(token_char));
        check_field("token_column", 32'(want.token_column), 32'(token_column));
        check_field("name_hash", want.name_hash, name_hash);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // operators, control codes, the top code, newline and a dot that ends alone
  task automatic test_single_chars();
    send_until_taken(8'h00);
    send_until_taken(8'h09);
    send_text(op_chars);
    send_until_taken(8'hff);
    send_until_taken(8'h7f);
    send_until_taken(CH_NEWLINE);
    send_text("!.+ .");
    send_until_taken(CH_NEWLINE);
  endtask

  // plain integers, trailing dot, second dot, letter right after digits, leading dot
  task automatic test_numbers();
    send_text("0 9. 12.34.5 7a .5\n");
  endtask

  // both keywords, a near miss, underscore lead, name cut by a dot and by the top code
  task automatic test_names_and_keywords();
    send_text("sub end SUB _x9 Z.end");
    send_until_taken(8'hff);
    send_until_taken(CH_NEWLINE);
  endtask

  // receiver holds off long enough for the input queue to fill and stall the sender
  task automatic test_backpressure();
    bit saved_idle;
    saved_idle = tx_idle_en;
    tx_idle_en = 1'b0;
    rx_hold_cycles = 80;
    send_text("alpha+42 .5 end\nq_1*(3.0)^sub\n");
    tx_idle_en = saved_idle;
  endtask

  // mostly well-formed tokens with random content, some raw noise that ignores
  // the consumed flag
  task automatic test_random_stream(input int n_items);
    int   first;
    int   kind;
    int   len;
    logic took;
    first = items_sent;
    while (items_sent - first < n_items) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1: begin
          len = $urandom_range(1, 5);
          repeat (len) send_until_taken(8'("0" + $urandom_range(0, 9)));
          if ($urandom_range(0, 2) == 0) begin
            send_until_taken(CH_DOT);
            repeat ($urandom_range(0, 3)) send_until_taken(8'("0" + $urandom_range(0, 9)));
          end
        end
        2, 3: begin
          if ($urandom_range(0, 4) == 0) begin
            send_text(kw_words[$urandom_range(0, 5)]);
          end else begin
            send_until_taken(rand_name_char(1'b1));
            repeat ($urandom_range(0, 7)) send_until_taken(rand_name_char(1'b0));
          end
        end
        4: send_until_taken(op_chars[$urandom_range(0, op_chars.len() - 1)]);
        5: repeat ($urandom_range(1, 3)) send_until_taken(rand_blank());
        6: send_until_taken(CH_NEWLINE);
        7: send_until_taken(CH_DOT);
        default: begin
          repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(0, 255)), took);
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    character <= 8'h00;
    lx        = LX_START;
    cur_col   = COLUMN_BITS'(1);
    tok_col   = COLUMN_BITS'(1);
    name_crc  = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed part with idling on both sides
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    test_single_chars();
    test_numbers();
    test_names_and_keywords();
    wait_drained();

    test_backpressure();
    wait_drained();

    test_random_stream(1150);
    wait_drained();

    // last part runs flat out
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_random_stream(500);
    wait_drained();

    // keep the clock running a while so a stray extra result would still be caught
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(RUN_LIMIT_NS);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
src/cst_pkg.sv
src/cst_front.sv
src/cst_queue.sv
src/cst_back.sv
src/char_stream_tokenizer_top.sv
bench/char_stream_tokenizer_top_test.sv
